/* design/spi_encoder_position_reader_unit_assert.svh */
// Assertion macros used by the encoder reader top-level design file.
`ifndef SPI_ENCODER_POSITION_READER_UNIT_ASSERT_SVH
`define SPI_ENCODER_POSITION_READER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SEPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* design/spi_enc_pkg.sv */
// Types and constants shared by the encoder reader modules.
package spi_enc_pkg;

	localparam int CH_W    = 3;
	localparam int BYTE_W  = 8;
	localparam int RAW_W   = 12;
	localparam int ANGLE_W = 13;
	localparam int VEL_W   = 29;
	localparam int OP_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [OP_W-1:0] OP_READ = 2'd0;
	localparam logic [OP_W-1:0] OP_ZERO = 2'd1;
	localparam logic [OP_W-1:0] OP_BYTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DIR_MASK    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd2;

	localparam logic [BYTE_W-1:0] CMD_READ = 8'h10;
	localparam logic [BYTE_W-1:0] CMD_POLL = 8'h00;
	localparam logic [BYTE_W-1:0] CMD_ZERO = 8'h70;
	localparam logic [BYTE_W-1:0] ACK_ZERO = 8'h80;

	localparam logic [7:0]  DIR_MASK_RESET    = 8'd0;
	localparam logic [15:0] SAMPLE_RATE_RESET = 16'd1000;
	localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd100;

	typedef enum logic [2:0] {
		KIND_TX    = 3'd0,
		KIND_DONE  = 3'd1,
		KIND_FAIL  = 3'd2,
		KIND_ZDONE = 3'd3,
		KIND_IGN   = 3'd4
	} kind_t;

	// One classified item travelling from the front to the back.
	typedef struct packed {
		kind_t             kind;
		logic [CH_W-1:0]   channel;
		logic [BYTE_W-1:0] tx_byte;
		logic [RAW_W-1:0]  raw;
	} work_t;

endpackage

/* design/spi_enc_queue.sv */
// Short first-in first-out queue between the front and the back.
module spi_enc_queue #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/spi_enc_front.sv */
// Front end: runs the SPI transaction sequencer and classifies each item.
module spi_enc_front #(
	parameter int NUM_ENCODERS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [spi_enc_pkg::OP_W-1:0]       op,
	input  logic [spi_enc_pkg::CH_W-1:0]       channel,
	input  logic [spi_enc_pkg::BYTE_W-1:0]     rx_byte,
	input  logic [7:0]                         retry_limit,
	output spi_enc_pkg::work_t                 work
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CMD,
		PH_POLL,
		PH_MSB,
		PH_LSB,
		PH_ZERO
	} phase_t;

	phase_t                          phase_q, phase_d;
	logic [spi_enc_pkg::CH_W-1:0]    active_ch_q, active_ch_d;
	logic [7:0]                      retry_q, retry_d;
	logic [3:0]                      nibble_q, nibble_d;
	logic                            ch_ok;

	assign ch_ok = ({1'b0, channel} < 4'(NUM_ENCODERS));

	always_comb begin
		phase_d       = phase_q;
		active_ch_d   = active_ch_q;
		retry_d       = retry_q;
		nibble_d      = nibble_q;
		work.kind     = spi_enc_pkg::KIND_IGN;
		work.channel  = active_ch_q;
		work.tx_byte  = '0;
		work.raw      = '0;
		unique case (op)
			spi_enc_pkg::OP_READ, spi_enc_pkg::OP_ZERO: begin
				if (phase_q == PH_IDLE && ch_ok) begin
					active_ch_d  = channel;
					retry_d      = '0;
					work.kind    = spi_enc_pkg::KIND_TX;
					work.channel = channel;
					if (op == spi_enc_pkg::OP_READ) begin
						phase_d      = PH_CMD;
						work.tx_byte = spi_enc_pkg::CMD_READ;
					end else begin
						phase_d      = PH_ZERO;
						work.tx_byte = spi_enc_pkg::CMD_ZERO;
					end
				end
			end
			spi_enc_pkg::OP_BYTE: begin
				unique case (phase_q)
					PH_IDLE: begin
						work.kind = spi_enc_pkg::KIND_IGN;
					end
					PH_CMD: begin
						work.kind    = spi_enc_pkg::KIND_TX;
						work.tx_byte = spi_enc_pkg::CMD_POLL;
						if (rx_byte == spi_enc_pkg::CMD_READ) begin
							phase_d = PH_MSB;
						end else begin
							retry_d = '0;
							phase_d = PH_POLL;
						end
					end
					PH_POLL: begin
						if (rx_byte == spi_enc_pkg::CMD_READ) begin
							phase_d      = PH_MSB;
							work.kind    = spi_enc_pkg::KIND_TX;
							work.tx_byte = spi_enc_pkg::CMD_POLL;
						end else if (retry_q >= retry_limit) begin
							phase_d   = PH_IDLE;
							retry_d   = '0;
							work.kind = spi_enc_pkg::KIND_FAIL;
						end else begin
							retry_d      = retry_q + 1'b1;
							work.kind    = spi_enc_pkg::KIND_TX;
							work.tx_byte = spi_enc_pkg::CMD_POLL;
						end
					end
					PH_MSB: begin
						nibble_d     = rx_byte[3:0];
						phase_d      = PH_LSB;
						work.kind    = spi_enc_pkg::KIND_TX;
						work.tx_byte = spi_enc_pkg::CMD_POLL;
					end
					PH_LSB: begin
						phase_d   = PH_IDLE;
						work.kind = spi_enc_pkg::KIND_DONE;
						work.raw  = {nibble_q, rx_byte};
					end
					PH_ZERO: begin
						if (rx_byte == spi_enc_pkg::ACK_ZERO) begin
							phase_d   = PH_IDLE;
							work.kind = spi_enc_pkg::KIND_ZDONE;
						end else begin
							work.kind    = spi_enc_pkg::KIND_TX;
							work.tx_byte = spi_enc_pkg::CMD_POLL;
						end
					end
					default: begin
						phase_d   = PH_IDLE;
						work.kind = spi_enc_pkg::KIND_IGN;
					end
				endcase
			end
			default: begin
				work.kind = spi_enc_pkg::KIND_IGN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			active_ch_q <= '0;
			retry_q     <= '0;
			nibble_q    <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			active_ch_q <= active_ch_d;
			retry_q     <= retry_d;
			nibble_q    <= nibble_d;
		end
	end

endmodule

/* design/spi_enc_back.sv */
// Back end: angle conversion, per-channel angle store, velocity and output register.
module spi_enc_back #(
	parameter int NUM_ENCODERS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spi_enc_pkg::work_t                 head,
	input  logic                               head_valid,
	output logic                               pop,
	input  logic [7:0]                         direction_mask,
	input  logic [15:0]                        sample_rate_hz,
	output logic                               out_valid,
	input  logic                               out_ready,
	output spi_enc_pkg::kind_t                 out_kind,
	output logic [spi_enc_pkg::CH_W-1:0]       out_channel,
	output logic [spi_enc_pkg::BYTE_W-1:0]     out_tx_byte,
	output logic signed [spi_enc_pkg::ANGLE_W-1:0] out_angle,
	output logic signed [spi_enc_pkg::VEL_W-1:0]   out_velocity
);

	localparam int LA_IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

	logic signed [spi_enc_pkg::ANGLE_W-1:0] last_angle_q [NUM_ENCODERS];

	logic                                   advance;
	logic [LA_IDX_W-1:0]                    idx;
	logic signed [spi_enc_pkg::ANGLE_W-1:0] last_sel;
	logic signed [13:0]                     a_full;
	logic signed [13:0]                     diff;
	logic signed [30:0]                     product;

	logic                                   valid_s1;
	spi_enc_pkg::kind_t                     kind_s1;
	logic [spi_enc_pkg::CH_W-1:0]           ch_s1;
	logic [spi_enc_pkg::BYTE_W-1:0]         tx_s1;
	logic signed [spi_enc_pkg::ANGLE_W-1:0] angle_s1;
	logic signed [13:0]                     diff_s1;

	assign advance  = !(out_valid && !out_ready);
	assign pop      = head_valid && advance;
	assign idx      = head.channel[LA_IDX_W-1:0];
	assign last_sel = last_angle_q[idx];

	always_comb begin
		a_full = $signed({2'b00, head.raw});
		if (direction_mask[head.channel]) begin
			a_full = 14'sd4096 - a_full;
		end
		if (a_full > 14'sd2048) begin
			a_full = a_full - 14'sd4096;
		end
		diff = a_full - {last_sel[spi_enc_pkg::ANGLE_W-1], last_sel};
	end

	assign product = diff_s1 * $signed({1'b0, sample_rate_hz});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENCODERS; i++) begin
				last_angle_q[i] <= '0;
			end
		end else if (pop && head.kind == spi_enc_pkg::KIND_DONE) begin
			last_angle_q[idx] <= a_full[spi_enc_pkg::ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			valid_s1  <= pop;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1 <= head.kind;
			ch_s1   <= head.channel;
			tx_s1   <= head.tx_byte;
			diff_s1 <= diff;
			unique case (head.kind)
				spi_enc_pkg::KIND_DONE: angle_s1 <= a_full[spi_enc_pkg::ANGLE_W-1:0];
				spi_enc_pkg::KIND_FAIL: angle_s1 <= last_sel;
				default:                angle_s1 <= '0;
			endcase
		end
		if (advance && valid_s1) begin
			out_kind    <= kind_s1;
			out_channel <= ch_s1;
			out_tx_byte <= tx_s1;
			out_angle   <= angle_s1;
			out_velocity <= (kind_s1 == spi_enc_pkg::KIND_DONE) ?
				product[spi_enc_pkg::VEL_W-1:0] : '0;
		end
	end

endmodule

/* design/spi_encoder_position_reader_unit.sv */
// A result passes through the queue, the angle stage and the output register, and output back-pressure can hold it.
// Throughput: one item per cycle; the front takes items while the four-entry queue has room.
// The back drains one entry per cycle whenever its output register is empty or being taken.
// Reset (arst_n low, asynchronous) idles the sequencer, empties the queue and pipeline,
// clears every stored channel angle and restores the register defaults.
module spi_encoder_position_reader_unit #(
	parameter int NUM_ENCODERS = 8,
	parameter int QUEUE_DEPTH  = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [15:0]                           s_tdata,  // channel[2:0], rx_byte[10:3]
	input  logic [spi_enc_pkg::OP_W-1:0]          s_tuser,  // op
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [55:0]                           m_tdata,  // channel_out[2:0], tx_byte[10:3],
	                                                        // angle_counts[23:11], velocity[52:24]
	output logic [2:0]                            m_tuser,  // kind
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [spi_enc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spi_enc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	`include "spi_encoder_position_reader_unit_assert.svh"

	logic [7:0]  dir_mask_q;
	logic [15:0] sample_rate_q;
	logic [7:0]  retry_limit_q;

	logic                   in_xfer;
	spi_enc_pkg::work_t     work;
	spi_enc_pkg::work_t     head;
	logic                   q_full;
	logic                   q_empty;
	logic                   q_pop;

	spi_enc_pkg::kind_t                          out_kind;
	logic [spi_enc_pkg::CH_W-1:0]                out_channel;
	logic [spi_enc_pkg::BYTE_W-1:0]              out_tx_byte;
	logic signed [spi_enc_pkg::ANGLE_W-1:0]      out_angle;
	logic signed [spi_enc_pkg::VEL_W-1:0]        out_velocity;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_mask_q    <= spi_enc_pkg::DIR_MASK_RESET;
			sample_rate_q <= spi_enc_pkg::SAMPLE_RATE_RESET;
			retry_limit_q <= spi_enc_pkg::RETRY_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				spi_enc_pkg::CFG_DIR_MASK:    dir_mask_q    <= cfg_data[7:0];
				spi_enc_pkg::CFG_SAMPLE_RATE: sample_rate_q <= cfg_data;
				spi_enc_pkg::CFG_RETRY_LIMIT: retry_limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign in_xfer  = s_tvalid && s_tready;

	spi_enc_front #(
		.NUM_ENCODERS(NUM_ENCODERS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_xfer),
		.op         (s_tuser),
		.channel    (s_tdata[2:0]),
		.rx_byte    (s_tdata[10:3]),
		.retry_limit(retry_limit_q),
		.work       (work)
	);

	spi_enc_queue #(
		.WIDTH($bits(spi_enc_pkg::work_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_xfer),
		.push_data(work),
		.pop      (q_pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	spi_enc_back #(
		.NUM_ENCODERS(NUM_ENCODERS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (!q_empty),
		.pop           (q_pop),
		.direction_mask(dir_mask_q),
		.sample_rate_hz(sample_rate_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_kind      (out_kind),
		.out_channel   (out_channel),
		.out_tx_byte   (out_tx_byte),
		.out_angle     (out_angle),
		.out_velocity  (out_velocity)
	);

	assign m_tuser = out_kind;
	assign m_tdata = {3'b000, out_velocity, out_angle, out_tx_byte, out_channel};

	`SEPR_ASSERT_NEXT(a_push_fills_queue, clk, arst_n, in_xfer, !q_empty)
	`SEPR_ASSERT_NOW(a_velocity_only_on_done, clk, arst_n,
		m_tvalid && out_kind != spi_enc_pkg::KIND_DONE, out_velocity == '0)
	`SEPR_ASSERT_NOW(a_angle_in_range, clk, arst_n,
		m_tvalid && out_kind == spi_enc_pkg::KIND_DONE,
		out_angle >= -13'sd2047 && out_angle <= 13'sd2048)

endmodule
